// ===== hw/rtl/bsmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary sensor / motor control package
// Item kinds, sequencer phase codes, command letters, drive constants and
// the packed result beat shared by the block.
// ----------------------------------------------------------------------------
package bsmc_pkg;

  // Item kinds carried on the input tuser
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_CMD    = 2'd2;

  // Reply codes
  localparam logic [1:0] REPLY_NONE   = 2'd0;
  localparam logic [1:0] REPLY_ACCEPT = 2'd1;
  localparam logic [1:0] REPLY_REJECT = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TICK_DIVIDE = 1'b0;
  localparam logic CFG_THRESHOLD   = 1'b1;

  // Configuration reset values
  localparam logic [4:0] TICK_DIVIDE_RST = 5'd10;
  localparam logic [9:0] THRESHOLD_RST   = 10'd256;
  localparam logic [4:0] TICK_DIVIDE_MAX = 5'd16;

  // Sensor sequencer phases
  localparam logic [2:0] PH_CENTRE_ON    = 3'd0;
  localparam logic [2:0] PH_CENTRE_OFF   = 3'd1;
  localparam logic [2:0] PH_LEFTMOST_ON  = 3'd2;
  localparam logic [2:0] PH_LEFTMOST_OFF = 3'd3;
  localparam logic [2:0] PH_LEFT_ON      = 3'd4;
  localparam logic [2:0] PH_LEFT_OFF     = 3'd5;

  // ADC channels of the three sensors
  localparam logic [2:0] CH_CENTRE   = 3'd2;
  localparam logic [2:0] CH_LEFTMOST = 3'd4;
  localparam logic [2:0] CH_LEFT     = 3'd3;

  // LED bits
  localparam logic [2:0] LED_CENTRE   = 3'b001;
  localparam logic [2:0] LED_LEFT     = 3'b010;
  localparam logic [2:0] LED_LEFTMOST = 3'b100;

  // Direction bits: bit0 forward, bit1 reverse
  localparam logic [1:0] DIR_STOP = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b10;

  // PWM duties
  localparam logic [7:0] DUTY_OFF  = 8'd0;
  localparam logic [7:0] DUTY_SLOW = 8'd100;
  localparam logic [7:0] DUTY_TRIM = 8'd250;
  localparam logic [7:0] DUTY_FULL = 8'd255;

  // Command letters
  localparam logic [3:0] CMD_HIGH_NIBBLE = 4'h6;
  localparam logic [7:0] CMD_FWD_LEFT    = 8'h61;
  localparam logic [7:0] CMD_FWD_STRAIT  = 8'h62;
  localparam logic [7:0] CMD_FWD_RIGHT   = 8'h63;
  localparam logic [7:0] CMD_REV_LEFT    = 8'h64;
  localparam logic [7:0] CMD_REV_STRAIT  = 8'h65;
  localparam logic [7:0] CMD_REV_RIGHT   = 8'h66;
  localparam logic [7:0] CMD_STOP        = 8'h67;

  // Result beat, last field in the lowest bits
  typedef struct packed {
    logic [3:0] pad;
    logic [1:0] reply;
    logic       inside_field;
    logic       start_conversion;
    logic [2:0] adc_channel;
    logic [2:0] led_mask;
    logic [7:0] right_duty;
    logic [7:0] left_duty;
    logic       reverse_drive;
    logic       forward_drive;
  } result_t;

endpackage

// ===== hw/rtl/boundary_sensor_motor_control.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boundary sensor motor control
// Tick-driven sensor sequencer, boundary check on the averaged floor
// readings and motor command decode, one result beat per input beat.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// s_axis    in         s_axis_tvalid/tready       tuser: func; tdata: sample, command
// m_axis    out        m_axis_tvalid/tready       tdata: drive, duties, LEDs, ADC, reply
// cfg       in         cfg_we_i (no wait)         cfg_addr_i, cfg_wdata_i
//
// Each beat passes an input register, then one pass of logic into the result
// register; one beat per cycle sustained while the output is not stalled.
// The state update happens as a beat moves from the input to the result register.
// rst_ni resets the control state: sequencer at PH_CENTRE_ON, inside flag set, drive forward.
// A stalled output holds its beat; the input register still takes one more beat.
// ----------------------------------------------------------------------------
module boundary_sensor_motor_control (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [9:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [9:0] sample, [17:10] command, [23:18] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [0] forward_drive, [1] reverse_drive,
                                      // [9:2] left_duty, [17:10] right_duty,
                                      // [20:18] led_mask, [23:21] adc_channel,
                                      // [24] start_conversion, [25] inside_field,
                                      // [27:26] reply, [31:28] zero
);

  // Configuration registers
  logic [4:0] tick_divide_q;
  logic [9:0] threshold_q;

  // Input register
  logic       in_valid_q;
  logic [1:0] in_func_q;
  logic [9:0] in_sample_q;
  logic [7:0] in_command_q;

  // Block state
  logic [3:0] tick_count_q, tick_count_d;
  logic [2:0] phase_q, phase_d;
  logic [9:0] centre_q, centre_d;
  logic [9:0] leftmost_q, leftmost_d;
  logic [9:0] left_q, left_d;
  logic       inside_q, inside_d;
  logic [1:0] dir_q, dir_d;
  logic [7:0] lpwm_q, lpwm_d;
  logic [7:0] rpwm_q, rpwm_d;
  logic [2:0] led_q, led_d;
  logic [2:0] chan_q, chan_d;

  // Result register
  logic                 out_valid_q;
  bsmc_pkg::result_t    out_q, out_d;

  logic       advance;
  logic       start;
  logic [1:0] reply;
  logic [4:0] div_eff;
  logic [4:0] count_inc;
  logic [11:0] sum;
  logic [11:0] thr3;
  logic        cmd_ok;

  // Handshake: move a beat on when the result register is free or drains
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_divide_q <= bsmc_pkg::TICK_DIVIDE_RST;
      threshold_q   <= bsmc_pkg::THRESHOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bsmc_pkg::CFG_TICK_DIVIDE: tick_divide_q <= cfg_wdata_i[4:0];
        bsmc_pkg::CFG_THRESHOLD:   threshold_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q    <= s_axis_tuser;
      in_sample_q  <= s_axis_tdata[9:0];
      in_command_q <= s_axis_tdata[17:10];
    end
  end

  // Clamp divider to 1..16, compare sum against three times the threshold
  always_comb begin
    if (tick_divide_q == 5'd0) begin
      div_eff = 5'd1;
    end else if (tick_divide_q > bsmc_pkg::TICK_DIVIDE_MAX) begin
      div_eff = bsmc_pkg::TICK_DIVIDE_MAX;
    end else begin
      div_eff = tick_divide_q;
    end
    count_inc = {1'b0, tick_count_q} + 5'd1;
    sum  = {2'b00, centre_q} + {2'b00, leftmost_q} + {2'b00, left_q};
    thr3 = {2'b00, threshold_q} + {1'b0, threshold_q, 1'b0};
    cmd_ok = (in_command_q[7:4] == bsmc_pkg::CMD_HIGH_NIBBLE) && !in_command_q[3];
  end

  // Next state for the beat in the input register
  always_comb begin
    tick_count_d = tick_count_q;
    phase_d      = phase_q;
    centre_d     = centre_q;
    leftmost_d   = leftmost_q;
    left_d       = left_q;
    inside_d     = inside_q;
    dir_d        = dir_q;
    lpwm_d       = lpwm_q;
    rpwm_d       = rpwm_q;
    led_d        = led_q;
    chan_d       = chan_q;
    start        = 1'b0;
    reply        = bsmc_pkg::REPLY_NONE;

    case (in_func_q)
      bsmc_pkg::FUNC_TICK: begin
        // divider and sequencer step
        if (count_inc >= div_eff) begin
          tick_count_d = 4'd0;
          case (phase_q)
            bsmc_pkg::PH_CENTRE_ON: begin
              chan_d  = bsmc_pkg::CH_CENTRE;
              led_d   = led_q | bsmc_pkg::LED_CENTRE;
              start   = 1'b1;
              phase_d = bsmc_pkg::PH_CENTRE_OFF;
            end
            bsmc_pkg::PH_CENTRE_OFF: begin
              led_d   = led_q & ~bsmc_pkg::LED_CENTRE;
              phase_d = bsmc_pkg::PH_LEFTMOST_ON;
            end
            bsmc_pkg::PH_LEFTMOST_ON: begin
              chan_d  = bsmc_pkg::CH_LEFTMOST;
              led_d   = led_q | bsmc_pkg::LED_LEFTMOST;
              start   = 1'b1;
              phase_d = bsmc_pkg::PH_LEFTMOST_OFF;
            end
            bsmc_pkg::PH_LEFTMOST_OFF: begin
              led_d   = led_q & ~bsmc_pkg::LED_LEFTMOST;
              phase_d = bsmc_pkg::PH_LEFT_ON;
            end
            bsmc_pkg::PH_LEFT_ON: begin
              chan_d  = bsmc_pkg::CH_LEFT;
              led_d   = led_q | bsmc_pkg::LED_LEFT;
              start   = 1'b1;
              phase_d = bsmc_pkg::PH_LEFT_OFF;
            end
            bsmc_pkg::PH_LEFT_OFF: begin
              led_d   = led_q & ~bsmc_pkg::LED_LEFT;
              phase_d = bsmc_pkg::PH_CENTRE_ON;
            end
            default: begin
              phase_d = bsmc_pkg::PH_CENTRE_ON;
            end
          endcase
        end else begin
          tick_count_d = count_inc[3:0];
        end
        // boundary check on the stored readings
        if (sum >= thr3) begin
          dir_d    = bsmc_pkg::DIR_REV;
          lpwm_d   = bsmc_pkg::DUTY_FULL;
          rpwm_d   = bsmc_pkg::DUTY_FULL;
          inside_d = 1'b0;
        end else if (!inside_q) begin
          dir_d    = bsmc_pkg::DIR_STOP;
          lpwm_d   = bsmc_pkg::DUTY_OFF;
          rpwm_d   = bsmc_pkg::DUTY_OFF;
          inside_d = 1'b1;
        end
      end
      bsmc_pkg::FUNC_SAMPLE: begin
        // store sample by phase, drop it in LED-on phases
        case (phase_q)
          bsmc_pkg::PH_CENTRE_OFF:   centre_d   = in_sample_q;
          bsmc_pkg::PH_LEFTMOST_OFF: leftmost_d = in_sample_q;
          bsmc_pkg::PH_LEFT_OFF:     left_d     = in_sample_q;
          default: ;
        endcase
      end
      bsmc_pkg::FUNC_CMD: begin
        if (!cmd_ok) begin
          reply = bsmc_pkg::REPLY_REJECT;
        end else begin
          reply = bsmc_pkg::REPLY_ACCEPT;
          if (inside_q) begin
            case (in_command_q)
              bsmc_pkg::CMD_FWD_LEFT: begin
                dir_d = bsmc_pkg::DIR_FWD;
                lpwm_d = bsmc_pkg::DUTY_SLOW; rpwm_d = bsmc_pkg::DUTY_FULL;
              end
              bsmc_pkg::CMD_FWD_STRAIT: begin
                dir_d = bsmc_pkg::DIR_FWD;
                lpwm_d = bsmc_pkg::DUTY_FULL; rpwm_d = bsmc_pkg::DUTY_FULL;
              end
              bsmc_pkg::CMD_FWD_RIGHT: begin
                dir_d = bsmc_pkg::DIR_FWD;
                lpwm_d = bsmc_pkg::DUTY_TRIM; rpwm_d = bsmc_pkg::DUTY_SLOW;
              end
              bsmc_pkg::CMD_REV_LEFT: begin
                dir_d = bsmc_pkg::DIR_REV;
                lpwm_d = bsmc_pkg::DUTY_SLOW; rpwm_d = bsmc_pkg::DUTY_FULL;
              end
              bsmc_pkg::CMD_REV_STRAIT: begin
                dir_d = bsmc_pkg::DIR_REV;
                lpwm_d = bsmc_pkg::DUTY_FULL; rpwm_d = bsmc_pkg::DUTY_FULL;
              end
              bsmc_pkg::CMD_REV_RIGHT: begin
                dir_d = bsmc_pkg::DIR_REV;
                lpwm_d = bsmc_pkg::DUTY_TRIM; rpwm_d = bsmc_pkg::DUTY_SLOW;
              end
              bsmc_pkg::CMD_STOP: begin
                dir_d = bsmc_pkg::DIR_STOP;
                lpwm_d = bsmc_pkg::DUTY_OFF; rpwm_d = bsmc_pkg::DUTY_OFF;
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // Pack the result from the updated state
  always_comb begin
    out_d                  = '0;
    out_d.forward_drive    = dir_d[0];
    out_d.reverse_drive    = dir_d[1];
    out_d.left_duty        = lpwm_d;
    out_d.right_duty       = rpwm_d;
    out_d.led_mask         = led_d;
    out_d.adc_channel      = chan_d;
    out_d.start_conversion = start;
    out_d.inside_field     = inside_d;
    out_d.reply            = reply;
  end

  // Commit state on each advancing beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= 4'd0;
      phase_q      <= bsmc_pkg::PH_CENTRE_ON;
      centre_q     <= 10'd0;
      leftmost_q   <= 10'd0;
      left_q       <= 10'd0;
      inside_q     <= 1'b1;
      dir_q        <= bsmc_pkg::DIR_FWD;
      lpwm_q       <= bsmc_pkg::DUTY_OFF;
      rpwm_q       <= bsmc_pkg::DUTY_OFF;
      led_q        <= 3'd0;
      chan_q       <= bsmc_pkg::CH_CENTRE;
    end else if (advance) begin
      tick_count_q <= tick_count_d;
      phase_q      <= phase_d;
      centre_q     <= centre_d;
      leftmost_q   <= leftmost_d;
      left_q       <= left_d;
      inside_q     <= inside_d;
      dir_q        <= dir_d;
      lpwm_q       <= lpwm_d;
      rpwm_q       <= rpwm_d;
      led_q        <= led_d;
      chan_q       <= chan_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  // Sequencer never leaves its six phases
  assert property (@(posedge clk_i) disable iff (!rst_ni) phase_q <= bsmc_pkg::PH_LEFT_OFF)
    else $error("sequencer phase out of range");

  // Outside the field the drive stays at full reverse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !inside_q |-> (dir_q == bsmc_pkg::DIR_REV && lpwm_q == bsmc_pkg::DUTY_FULL &&
                   rpwm_q == bsmc_pkg::DUTY_FULL))
    else $error("drive not full reverse while outside");

  // A conversion start lights the LED of the selected channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.start_conversion) |->
      ((out_q.adc_channel == bsmc_pkg::CH_CENTRE && out_q.led_mask[0]) ||
       (out_q.adc_channel == bsmc_pkg::CH_LEFT && out_q.led_mask[1]) ||
       (out_q.adc_channel == bsmc_pkg::CH_LEFTMOST && out_q.led_mask[2])))
    else $error("conversion start without matching LED");

  // A reply only follows a command beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_func_q != bsmc_pkg::FUNC_CMD) |=> out_q.reply == bsmc_pkg::REPLY_NONE)
    else $error("reply on a non-command beat");

endmodule
